FILE: rtl/dpd_pkg.sv
// Package: shared constants and types of the packet deframer.
package dpd_pkg;

  localparam int MaxPacket = 32;
  localparam int MaxTotal  = 4096;

  localparam int ByteW  = 8;
  localparam int CountW = 13;
  localparam int LenW   = 6;
  localparam int CfgW   = 13;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_BEGIN   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_START = 3'd1,
    ERR_BAD_LEN   = 3'd2,
    ERR_TRUNC     = 3'd3,
    ERR_CHECKSUM  = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    CFG_START_CODE    = 2'd0,
    CFG_BUFFER_LIMIT  = 2'd1,
    CFG_STOP_ON_SHORT = 2'd2
  } cfg_idx_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_START   = 5'b00010,
    PH_LEN     = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_t;

endpackage

FILE: rtl/dpd_if.sv
// Interfaces: input and result item channels of the packet deframer.
interface dpd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface dpd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [12:0] byte_index;
  logic [2:0]  error_code;

  modport source (output valid, output kind, output payload_byte, output byte_index,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input payload_byte, input byte_index,
                  input error_code, output ready);
endinterface

FILE: rtl/dive_packet_deframer_unit.sv
// Top level: packet deframer with input register, state update and result register.
// Latency: an accepted item passes the input register, then the result register, where its
// result is held; items without a result only update state.
// Throughput: one item per cycle while out_if.ready keeps the result register free.
// Reset (rst_n, synchronous, active low): idle phase, counters cleared, registers
// start_code 8, buffer_limit 4096, stop_on_short 1, both item stages empty.
module dive_packet_deframer_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  dpd_in_if.sink                  in_if,
  dpd_out_if.source               out_if,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_idx,
  input  logic [dpd_pkg::CfgW-1:0] cfg_data
);

  localparam logic [dpd_pkg::CountW-1:0] MaxTotalC = dpd_pkg::CountW'(dpd_pkg::MaxTotal);
  localparam logic [dpd_pkg::ByteW-1:0]  MaxPktB   = dpd_pkg::ByteW'(dpd_pkg::MaxPacket);
  localparam logic [dpd_pkg::LenW-1:0]   MaxPktL   = dpd_pkg::LenW'(dpd_pkg::MaxPacket);

  // configuration
  logic [dpd_pkg::ByteW-1:0]  start_code_r;
  logic [dpd_pkg::CountW-1:0] buf_lim_r;
  logic                       stop_short_r;

  // input stage
  logic                      s1_valid_r;
  dpd_pkg::op_t              op_r;
  logic [dpd_pkg::ByteW-1:0] byte_r;

  // deframer state
  dpd_pkg::phase_t            phase_r, phase_nxt;
  logic [dpd_pkg::ByteW-1:0]  xor_r, xor_nxt;
  logic [dpd_pkg::LenW-1:0]   len_r, len_nxt;
  logic [dpd_pkg::LenW-1:0]   cnt_r, cnt_nxt;
  logic [dpd_pkg::CountW-1:0] tot_r, tot_nxt;

  // result stage
  logic                       out_valid_r;
  dpd_pkg::kind_t             kind_r;
  logic [dpd_pkg::ByteW-1:0]  data_r;
  logic [dpd_pkg::CountW-1:0] idx_r;
  dpd_pkg::err_t              err_r;

  logic                       res_v;
  dpd_pkg::kind_t             res_kind;
  logic [dpd_pkg::ByteW-1:0]  res_data;
  logic [dpd_pkg::CountW-1:0] res_idx;
  dpd_pkg::err_t              res_err;

  logic                       out_free;
  logic                       s1_move;
  logic                       in_acc;
  logic [dpd_pkg::CountW-1:0] limit;
  logic [dpd_pkg::CountW-1:0] tot_inc;
  logic [dpd_pkg::LenW-1:0]   cnt_inc;
  logic [dpd_pkg::ByteW-1:0]  xor_chk;
  logic                       is_tmo;

  assign out_free    = !out_valid_r || out_if.ready;
  assign s1_move     = s1_valid_r && out_free;
  assign in_if.ready = !s1_valid_r || s1_move;
  assign in_acc      = in_if.valid && in_if.ready;

  assign limit   = (buf_lim_r < MaxTotalC) ? buf_lim_r : MaxTotalC;
  assign tot_inc = tot_r + dpd_pkg::CountW'(1);
  assign cnt_inc = cnt_r + dpd_pkg::LenW'(1);
  assign xor_chk = xor_r ^ byte_r;
  assign is_tmo  = (op_r == dpd_pkg::OP_TIMEOUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= dpd_pkg::ByteW'(8);
      buf_lim_r    <= MaxTotalC;
      stop_short_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        dpd_pkg::CFG_START_CODE:    start_code_r <= cfg_data[dpd_pkg::ByteW-1:0];
        dpd_pkg::CFG_BUFFER_LIMIT:  buf_lim_r    <= cfg_data[dpd_pkg::CountW-1:0];
        dpd_pkg::CFG_STOP_ON_SHORT: stop_short_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= dpd_pkg::op_t'(in_if.operation);
      byte_r <= in_if.rx_byte;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    tot_nxt   = tot_r;
    res_v     = 1'b0;
    res_kind  = dpd_pkg::KIND_DATA;
    res_data  = '0;
    res_idx   = tot_r;
    res_err   = dpd_pkg::ERR_NONE;
    if (op_r == dpd_pkg::OP_BEGIN) begin
      xor_nxt   = '0;
      len_nxt   = '0;
      cnt_nxt   = '0;
      tot_nxt   = '0;
      phase_nxt = dpd_pkg::PH_START;
      if (limit == '0) begin
        phase_nxt = dpd_pkg::PH_IDLE;
        res_v     = 1'b1;
        res_kind  = dpd_pkg::KIND_DONE;
        res_idx   = '0;
      end
    end else if (op_r != dpd_pkg::OP_NONE) begin
      unique case (phase_r)
        dpd_pkg::PH_IDLE: ;
        dpd_pkg::PH_START: begin
          if (is_tmo) begin
            phase_nxt = dpd_pkg::PH_IDLE;
            res_v     = 1'b1;
            res_kind  = dpd_pkg::KIND_DONE;
          end else if (byte_r != start_code_r) begin
            phase_nxt = dpd_pkg::PH_IDLE;
            res_v     = 1'b1;
            res_kind  = dpd_pkg::KIND_ERR;
            res_err   = dpd_pkg::ERR_BAD_START;
          end else begin
            xor_nxt   = byte_r;
            phase_nxt = dpd_pkg::PH_LEN;
          end
        end
        dpd_pkg::PH_LEN: begin
          if (is_tmo || byte_r > MaxPktB) begin
            phase_nxt = dpd_pkg::PH_IDLE;
            res_v     = 1'b1;
            res_kind  = dpd_pkg::KIND_ERR;
            res_err   = dpd_pkg::ERR_BAD_LEN;
          end else begin
            xor_nxt   = xor_chk;
            len_nxt   = byte_r[dpd_pkg::LenW-1:0];
            cnt_nxt   = '0;
            phase_nxt = (byte_r[dpd_pkg::LenW-1:0] == '0) ? dpd_pkg::PH_CHECK
                                                          : dpd_pkg::PH_PAYLOAD;
          end
        end
        dpd_pkg::PH_PAYLOAD: begin
          if (is_tmo) begin
            phase_nxt = dpd_pkg::PH_IDLE;
            res_v     = 1'b1;
            res_kind  = dpd_pkg::KIND_ERR;
            res_err   = dpd_pkg::ERR_TRUNC;
          end else begin
            xor_nxt  = xor_chk;
            tot_nxt  = tot_inc;
            cnt_nxt  = cnt_inc;
            if (cnt_inc >= len_r || tot_inc >= limit) begin
              phase_nxt = dpd_pkg::PH_CHECK;
            end
            res_v    = 1'b1;
            res_kind = dpd_pkg::KIND_DATA;
            res_data = byte_r;
          end
        end
        dpd_pkg::PH_CHECK: begin
          xor_nxt = xor_chk;
          if (is_tmo || xor_chk != '0) begin
            phase_nxt = dpd_pkg::PH_IDLE;
            res_v     = 1'b1;
            res_kind  = dpd_pkg::KIND_ERR;
            res_err   = dpd_pkg::ERR_CHECKSUM;
          end else if ((stop_short_r && len_r != MaxPktL) || tot_r >= limit) begin
            phase_nxt = dpd_pkg::PH_IDLE;
            res_v     = 1'b1;
            res_kind  = dpd_pkg::KIND_DONE;
          end else begin
            phase_nxt = dpd_pkg::PH_START;
          end
        end
        default: phase_nxt = dpd_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dpd_pkg::PH_IDLE;
      xor_r   <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      tot_r   <= '0;
    end else if (s1_move) begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      tot_r   <= tot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_move && res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && res_v) begin
      kind_r <= res_kind;
      data_r <= res_data;
      idx_r  <= res_idx;
      err_r  <= res_err;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = kind_r;
  assign out_if.payload_byte = data_r;
  assign out_if.byte_index   = idx_r;
  assign out_if.error_code   = err_r;

endmodule

FILE: tb/dpd_frame_checker.sv
// Checker for the packet deframer: predicts the result of each item and compares it.
`timescale 1ns / 1ps
module dpd_frame_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  dpd_in_if                        in_ch,
  dpd_out_if                       out_ch,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_idx,
  input  logic [dpd_pkg::CfgW-1:0] cfg_data,
  output int                       outstanding,
  output int                       fail_count
);

  typedef struct packed {
    dpd_pkg::kind_t             kind;
    logic [dpd_pkg::ByteW-1:0]  data;
    logic [dpd_pkg::CountW-1:0] index;
    dpd_pkg::err_t              err;
  } frame_result_t;

  logic [dpd_pkg::ByteW-1:0]  start_code;
  logic [dpd_pkg::CountW-1:0] buffer_limit;
  logic                       stop_on_short;

  dpd_pkg::phase_t            phase;
  logic [dpd_pkg::ByteW-1:0]  running_xor;
  logic [dpd_pkg::LenW-1:0]   pkt_len;
  logic [dpd_pkg::LenW-1:0]   pkt_seen;
  logic [dpd_pkg::CountW-1:0] total;

  frame_result_t     expected_q[$];
  int                fails = 0;

  function automatic int active_limit();
    return (buffer_limit < dpd_pkg::MaxTotal) ? int'(buffer_limit) : dpd_pkg::MaxTotal;
  endfunction

  function automatic frame_result_t make_result(dpd_pkg::kind_t k,
                                                logic [dpd_pkg::ByteW-1:0] d,
                                                logic [dpd_pkg::CountW-1:0] idx,
                                                dpd_pkg::err_t e);
    frame_result_t r;
    r.kind  = k;
    r.data  = d;
    r.index = idx;
    r.err   = e;
    return r;
  endfunction

  function automatic bit close_download(dpd_pkg::kind_t k, dpd_pkg::err_t e,
                                        output frame_result_t res);
    phase = dpd_pkg::PH_IDLE;
    res   = make_result(k, '0, total, e);
    return 1'b1;
  endfunction

  // One item of the deframer; returns 1 when the item produces a result.
  function automatic bit deframe_step(dpd_pkg::op_t op, logic [dpd_pkg::ByteW-1:0] b,
                                      output frame_result_t res);
    logic [dpd_pkg::CountW-1:0] idx;
    res = make_result(dpd_pkg::KIND_DATA, '0, '0, dpd_pkg::ERR_NONE);
    if (op == dpd_pkg::OP_BEGIN) begin
      running_xor = '0;
      pkt_len     = '0;
      pkt_seen    = '0;
      total       = '0;
      phase       = dpd_pkg::PH_START;
      if (active_limit() == 0)
        return close_download(dpd_pkg::KIND_DONE, dpd_pkg::ERR_NONE, res);
      return 1'b0;
    end
    if (op == dpd_pkg::OP_NONE || phase == dpd_pkg::PH_IDLE) return 1'b0;
    case (phase)
      dpd_pkg::PH_START: begin
        if (op == dpd_pkg::OP_TIMEOUT)
          return close_download(dpd_pkg::KIND_DONE, dpd_pkg::ERR_NONE, res);
        if (b != start_code)
          return close_download(dpd_pkg::KIND_ERR, dpd_pkg::ERR_BAD_START, res);
        running_xor = b;
        phase       = dpd_pkg::PH_LEN;
      end
      dpd_pkg::PH_LEN: begin
        if (op == dpd_pkg::OP_TIMEOUT || b > dpd_pkg::MaxPacket)
          return close_download(dpd_pkg::KIND_ERR, dpd_pkg::ERR_BAD_LEN, res);
        running_xor ^= b;
        pkt_len     = b[dpd_pkg::LenW-1:0];
        pkt_seen    = '0;
        phase       = (pkt_len == 0) ? dpd_pkg::PH_CHECK : dpd_pkg::PH_PAYLOAD;
      end
      dpd_pkg::PH_PAYLOAD: begin
        idx = total;
        if (op == dpd_pkg::OP_TIMEOUT)
          return close_download(dpd_pkg::KIND_ERR, dpd_pkg::ERR_TRUNC, res);
        running_xor ^= b;
        total       = total + 1'b1;
        pkt_seen    = pkt_seen + 1'b1;
        if (pkt_seen >= pkt_len || total >= active_limit()) phase = dpd_pkg::PH_CHECK;
        res = make_result(dpd_pkg::KIND_DATA, b, idx, dpd_pkg::ERR_NONE);
        return 1'b1;
      end
      dpd_pkg::PH_CHECK: begin
        if (op == dpd_pkg::OP_TIMEOUT)
          return close_download(dpd_pkg::KIND_ERR, dpd_pkg::ERR_CHECKSUM, res);
        running_xor ^= b;
        if (running_xor != 0)
          return close_download(dpd_pkg::KIND_ERR, dpd_pkg::ERR_CHECKSUM, res);
        if (stop_on_short && pkt_len != dpd_pkg::MaxPacket)
          return close_download(dpd_pkg::KIND_DONE, dpd_pkg::ERR_NONE, res);
        if (total >= active_limit())
          return close_download(dpd_pkg::KIND_DONE, dpd_pkg::ERR_NONE, res);
        phase = dpd_pkg::PH_START;
      end
      default: phase = dpd_pkg::PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  function automatic int field_diff(string name, int want, int got);
    if (want != got)
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    return int'(want != got);
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    bit            produced;
    if (!rst_n) begin
      start_code    = 8'd8;
      buffer_limit  = dpd_pkg::CountW'(dpd_pkg::MaxTotal);
      stop_on_short = 1'b1;
      phase         = dpd_pkg::PH_IDLE;
      running_xor   = '0;
      pkt_len       = '0;
      pkt_seen      = '0;
      total         = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (dpd_pkg::cfg_idx_t'(cfg_idx))
          dpd_pkg::CFG_START_CODE:    start_code    = cfg_data[dpd_pkg::ByteW-1:0];
          dpd_pkg::CFG_BUFFER_LIMIT:  buffer_limit  = cfg_data[dpd_pkg::CountW-1:0];
          dpd_pkg::CFG_STOP_ON_SHORT: stop_on_short = cfg_data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        produced = deframe_step(dpd_pkg::op_t'(in_ch.operation), in_ch.rx_byte, want);
        if (produced) expected_q = {expected_q, want};
      end
      if (out_ch.valid && out_ch.ready) begin
        got = make_result(dpd_pkg::kind_t'(out_ch.kind), out_ch.payload_byte,
                          out_ch.byte_index, dpd_pkg::err_t'(out_ch.error_code));
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing pending, expected none actual kind %0d index %0d",
                   $time, got.kind, got.index);
          fails++;
        end else begin
          want = expected_q.pop_front();
          fails += field_diff("kind", int'(want.kind), int'(got.kind))
                 + field_diff("payload_byte", int'(want.data), int'(got.data))
                 + field_diff("byte_index", int'(want.index), int'(got.index))
                 + field_diff("error_code", int'(want.err), int'(got.err));
        end
      end
    end
    outstanding <= expected_q.size();
    fail_count  <= fails;
  end

endmodule

FILE: tb/dive_packet_deframer_unit_tb.sv
// Testbench top: clock, reset, stimulus and verdict for the packet deframer.
`timescale 1ns / 1ps
module dive_packet_deframer_unit_tb;

  localparam int HoldCycles = 80;
  localparam int StallLimit = 2000;

  typedef enum int {
    FAULT_NONE,
    FAULT_TRUNC,
    FAULT_CHECK_TIMEOUT,
    FAULT_BAD_CHECK
  } fault_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [1:0]               cfg_idx;
  logic [dpd_pkg::CfgW-1:0] cfg_data;

  int outstanding;
  int fail_count;
  int stall_cycles = 0;
  int items_sent   = 0;
  bit hold_req     = 1'b0;
  bit calm         = 1'b0;

  logic [dpd_pkg::ByteW-1:0] cur_start;
  int                        cur_limit;
  bit                        cur_sos;

  dpd_in_if  in_ch ();
  dpd_out_if out_ch ();

  dive_packet_deframer_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  dpd_frame_checker frame_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 32);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("dive_packet_deframer_unit_tb: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(dpd_pkg::op_t op, logic [dpd_pkg::ByteW-1:0] b);
    while (!calm && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.rx_byte   <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // data byte, now and then preceded by an unused operation
  task automatic send_byte(logic [dpd_pkg::ByteW-1:0] b);
    if ($urandom_range(99) < 3) send_item(dpd_pkg::OP_NONE, 8'($urandom));
    send_item(dpd_pkg::OP_BYTE, b);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [dpd_pkg::ByteW-1:0] sc, int lim, bit sos);
    cfg_we   <= 1'b1;
    cfg_idx  <= dpd_pkg::CFG_START_CODE;
    cfg_data <= dpd_pkg::CfgW'(sc);
    @(posedge clk);
    cfg_idx  <= dpd_pkg::CFG_BUFFER_LIMIT;
    cfg_data <= dpd_pkg::CfgW'(lim);
    @(posedge clk);
    cfg_idx  <= dpd_pkg::CFG_STOP_ON_SHORT;
    cfg_data <= dpd_pkg::CfgW'(sos);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_start = sc;
    cur_limit = (lim > dpd_pkg::MaxTotal) ? dpd_pkg::MaxTotal : lim;
    cur_sos   = sos;
  endtask

  // one download: mostly well-formed packets, with broken ones mixed in
  task automatic run_download();
    int                        total;
    int                        pick;
    int                        len;
    int                        take;
    int                        cut;
    bit                        live;
    fault_t                    fault;
    logic [dpd_pkg::ByteW-1:0] chk;
    logic [dpd_pkg::ByteW-1:0] pl;
    send_item(dpd_pkg::OP_BEGIN, 8'($urandom));
    total = 0;
    live  = (cur_limit != 0);
    while (live) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_item(dpd_pkg::OP_TIMEOUT, 8'($urandom));
        live = 1'b0;
      end else if (pick < 7) begin
        send_byte(cur_start ^ 8'($urandom_range(1, 255)));
        live = 1'b0;
      end else if (pick < 10) begin
        send_byte(cur_start);
        if ($urandom_range(1)) send_item(dpd_pkg::OP_TIMEOUT, 8'($urandom));
        else send_byte(8'($urandom_range(dpd_pkg::MaxPacket + 1, 255)));
        live = 1'b0;
      end else if (pick < 12) begin
        send_item(dpd_pkg::OP_BEGIN, 8'($urandom));
        total = 0;
        live  = (cur_limit != 0);
      end else begin
        pick  = $urandom_range(99);
        fault = (pick < 4) ? FAULT_TRUNC :
                (pick < 7) ? FAULT_CHECK_TIMEOUT :
                (pick < 10) ? FAULT_BAD_CHECK : FAULT_NONE;
        len  = ($urandom_range(99) < 45) ? dpd_pkg::MaxPacket
                                         : $urandom_range(0, dpd_pkg::MaxPacket);
        take = (len < cur_limit - total) ? len : cur_limit - total;
        cut  = (fault == FAULT_TRUNC && take > 0) ? $urandom_range(0, take - 1) : take;
        send_byte(cur_start);
        send_byte(8'(len));
        chk = cur_start ^ 8'(len);
        for (int i = 0; i < cut; i++) begin
          pl  = 8'($urandom);
          chk ^= pl;
          send_byte(pl);
        end
        total += cut;
        live  = 1'b0;
        if (cut < take || fault == FAULT_CHECK_TIMEOUT) begin
          send_item(dpd_pkg::OP_TIMEOUT, 8'($urandom));
        end else if (fault == FAULT_BAD_CHECK) begin
          send_byte(chk ^ (8'd1 << $urandom_range(0, 7)));
        end else begin
          send_byte(chk);
          live = !((cur_sos && len != dpd_pkg::MaxPacket) || total >= cur_limit);
        end
      end
    end
    // stray traffic while idle
    if ($urandom_range(99) < 15)
      send_item(dpd_pkg::op_t'(2'($urandom_range(0, 1))), 8'($urandom));
    if ($urandom_range(99) < 10) drain();
  endtask

  task automatic run_phase(int budget);
    int first;
    first = items_sent;
    while (items_sent - first < budget) run_download();
    drain();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = dpd_pkg::OP_NONE;
    in_ch.rx_byte   = '0;
    cfg_we          = 1'b0;
    cfg_idx         = dpd_pkg::CFG_START_CODE;
    cfg_data        = '0;
    cur_start       = 8'd8;
    cur_limit       = dpd_pkg::MaxTotal;
    cur_sos         = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ignored while idle
    send_item(dpd_pkg::OP_BYTE, 8'hFF);
    send_item(dpd_pkg::OP_TIMEOUT, 8'h00);
    send_item(dpd_pkg::OP_NONE, 8'h08);
    // timeout where a start byte is due
    send_item(dpd_pkg::OP_BEGIN, 8'h00);
    send_item(dpd_pkg::OP_TIMEOUT, 8'h00);
    // wrong start code
    send_item(dpd_pkg::OP_BEGIN, 8'h00);
    send_item(dpd_pkg::OP_BYTE, 8'hFF);
    // timeout on length, then length above maximum
    send_item(dpd_pkg::OP_BEGIN, 8'h00);
    send_item(dpd_pkg::OP_BYTE, 8'h08);
    send_item(dpd_pkg::OP_TIMEOUT, 8'h00);
    send_item(dpd_pkg::OP_BEGIN, 8'h00);
    send_item(dpd_pkg::OP_BYTE, 8'h08);
    send_item(dpd_pkg::OP_BYTE, 8'd33);
    // zero length packet, short so the download ends
    send_item(dpd_pkg::OP_BEGIN, 8'h00);
    send_item(dpd_pkg::OP_BYTE, 8'h08);
    send_item(dpd_pkg::OP_BYTE, 8'h00);
    send_item(dpd_pkg::OP_BYTE, 8'h08);
    // short packet with extreme payload values
    send_item(dpd_pkg::OP_BEGIN, 8'h00);
    send_item(dpd_pkg::OP_BYTE, 8'h08);
    send_item(dpd_pkg::OP_BYTE, 8'h02);
    send_item(dpd_pkg::OP_BYTE, 8'h00);
    send_item(dpd_pkg::OP_BYTE, 8'hFF);
    send_item(dpd_pkg::OP_BYTE, 8'h08 ^ 8'h02 ^ 8'h00 ^ 8'hFF);
    drain();

    run_phase(100);

    configure(8'h00, 8191, 1'b0);
    hold_req = 1'b1;
    run_phase(130);

    configure(8'hFF, 0, 1'b1);
    repeat (6) run_download();
    drain();

    configure(8'($urandom), 40, 1'b0);
    calm = 1'b1;
    run_phase(120);
    calm = 1'b0;

    configure(8'($urandom), 1, 1'b0);
    run_phase(80);

    configure(8'($urandom), $urandom_range(1, 100), 1'($urandom_range(0, 1)));
    run_phase(120);

    configure(8'h08, dpd_pkg::MaxTotal, 1'b1);
    run_phase(100);

    repeat (6) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("dive_packet_deframer_unit_tb: clean");
    end else begin
      $display("dive_packet_deframer_unit_tb: errors");
    end
    $finish;
  end

endmodule
